/* design/b64d_pkg.sv */
// Shared constants, types and the character classifier of the base64 stream decoder.
package b64d_pkg;

    // Width of the per-message decoded byte counter (legal range 8 to 32).
    localparam int COUNT_WIDTH = 16;
    // Compare width: holds the counter plus three and the 16-bit output limit.
    localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [CMP_W-1:0] COUNT_MAX_X = CMP_W'({COUNT_WIDTH{1'b1}});

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'hFFFF;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE = 2'd1;
    localparam logic [1:0] FILL_TWO = 2'd2;
    localparam logic [1:0] FILL_THREE = 2'd3;

    typedef struct packed {
        logic       is_sextet;
        logic       is_end;
        logic [5:0] sextet;
    } t_class;

    // One unit of work for the back end: up to three bytes plus an optional report.
    typedef struct packed {
        logic [2:0]       mask;
        logic [2:0][7:0]  bytes;
        logic             is_end;
        logic [15:0]      length;
        logic             err;
    } t_job;

    typedef struct packed {
        t_job head;
        logic empty;
        logic full;
    } t_qstat;

    function automatic t_class classify(input logic [7:0] c);
        t_class r;
        r.is_sextet = 1'b1;
        r.is_end    = 1'b0;
        r.sextet    = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.sextet = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.sextet = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.sextet = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.sextet = 6'd62;
        end else if (c == 8'h2F) begin
            r.sextet = 6'd63;
        end else if (c == 8'h3D || c == 8'h00) begin
            r.is_sextet = 1'b0;
            r.is_end    = 1'b1;
        end else begin
            r.is_sextet = 1'b0;
        end
        return r;
    endfunction

endpackage

/* design/b64d_front.sv */
// Front end: classifies characters, collects sextets and builds output jobs.
module b64d_front import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0]            r_output_limit;
    logic [17:0]            r_group;
    logic [1:0]             r_fill;
    logic [COUNT_WIDTH-1:0] r_count;

    t_class                 cls;
    logic                   accept;
    logic                   group_done;
    logic [1:0]             nbytes;
    logic [CMP_W-1:0]       count_x;
    logic [CMP_W-1:0]       limit_x;
    logic [CMP_W-1:0]       next_x;
    logic [CMP_W-1:0]       pos_x;
    logic [23:0]            word;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [2:0]             job_mask;
    logic [2:0][7:0]        job_bytes;
    logic                   job_err;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_full;
    assign cls         = classify(i_char);
    assign accept      = i_valid && !i_full;
    assign group_done  = cls.is_sextet && (r_fill == FILL_THREE);
    assign word        = {r_group, cls.sextet};
    assign count_x     = CMP_W'(r_count);
    assign limit_x     = CMP_W'(r_output_limit);

    always_comb begin
        job_bytes = '0;
        nbytes    = 2'd0;
        job_err   = 1'b0;
        if (cls.is_end) begin
            case (r_fill)
                FILL_ONE: begin
                    job_err = 1'b1;
                end
                FILL_TWO: begin
                    nbytes       = 2'd1;
                    job_bytes[0] = r_group[11:4];
                end
                FILL_THREE: begin
                    nbytes       = 2'd2;
                    job_bytes[0] = r_group[17:10];
                    job_bytes[1] = r_group[9:2];
                end
                default: begin
                    nbytes = 2'd0;
                end
            endcase
        end else begin
            nbytes       = 2'd3;
            job_bytes[0] = word[23:16];
            job_bytes[1] = word[15:8];
            job_bytes[2] = word[7:0];
        end
    end

    // A byte is sent only while the count is neither saturated nor past the limit.
    always_comb begin
        job_mask = '0;
        for (int i = 0; i < 3; i++) begin
            pos_x = count_x + CMP_W'(i);
            job_mask[i] = (i < int'(nbytes)) && (pos_x < COUNT_MAX_X) && (pos_x < limit_x);
        end
    end

    always_comb begin
        next_x = count_x + CMP_W'(nbytes);
        if (next_x > COUNT_MAX_X) begin
            next_x = COUNT_MAX_X;
        end
        n_count = next_x[COUNT_WIDTH-1:0];
    end

    assign o_job  = {job_mask, job_bytes, cls.is_end, next_x[15:0], job_err};
    assign o_push = accept && (cls.is_end || (group_done && (job_mask != 3'b000)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= OUTPUT_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_output_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_fill  <= FILL_EMPTY;
            r_count <= '0;
        end else if (accept) begin
            if (cls.is_end) begin
                r_group <= '0;
                r_fill  <= FILL_EMPTY;
                r_count <= '0;
            end else if (group_done) begin
                r_group <= '0;
                r_fill  <= FILL_EMPTY;
                r_count <= n_count;
            end else if (cls.is_sextet) begin
                r_group <= {r_group[11:0], cls.sextet};
                r_fill  <= r_fill + 2'd1;
            end
        end
    end

endmodule

/* design/b64d_queue.sv */
// Small job queue between the front end and the back end.
module b64d_queue import b64d_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_qstat o_stat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_stat.head  = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

/* design/b64d_back.sv */
// Back end: serializes queued jobs into result items through an output register.
module b64d_back import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qstat      i_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data,
    output logic        o_last,
    output logic        o_user
);

    logic [2:0]  r_sent;
    logic        r_valid;
    logic [31:0] r_data;
    logic        r_last;
    logic        r_user;

    logic [2:0]  remaining;
    logic [2:0]  pick;
    logic        load;
    logic        item_last;
    logic [31:0] n_data;
    logic        n_user;

    assign remaining = i_stat.head.mask & ~r_sent;
    assign pick      = remaining & (~remaining + 3'd1);
    assign load      = !i_stat.empty && (!r_valid || i_ready);

    always_comb begin
        n_data    = '0;
        n_user    = KIND_DATA;
        item_last = 1'b0;
        if (remaining != 3'b000) begin
            case (pick)
                3'b001:  n_data[7:0] = i_stat.head.bytes[0];
                3'b010:  n_data[7:0] = i_stat.head.bytes[1];
                3'b100:  n_data[7:0] = i_stat.head.bytes[2];
                default: n_data[7:0] = 8'h00;
            endcase
            // The last data byte closes the job unless a report follows it.
            item_last = !i_stat.head.is_end && ((remaining & ~pick) == 3'b000);
        end else begin
            n_user       = KIND_REPORT;
            n_data[23:8] = i_stat.head.length;
            n_data[24]   = i_stat.head.err;
            item_last    = 1'b1;
        end
    end

    assign o_pop = load && item_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sent  <= item_last ? 3'b000 : (r_sent | pick);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_last <= item_last;
            r_user <= n_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

endmodule

/* design/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder.
//
// The slave channel takes one encoded character per item in s_axis_tdata[7:0].
// Alphabet characters fill groups of four sextets; every full group yields three
// data items. Other characters are skipped, except '=' and NUL, which close the
// message: any partial group is flushed and a report item (tuser high) carries
// the decoded length and the lone-sextet flag. tlast marks the final item that
// one character causes.
// The configuration channel writes the per-message output limit (reset 65535);
// bytes beyond it are counted but not sent. Write it only while the block is idle.
// Throughput: one character per cycle; the front end never waits on the output
// unless the four-entry job queue is full, and the back end sends one item per
// cycle through its output register while m_axis_tready is high. With the queue
// empty, an accepted character passes the job queue and the output register
// before m_axis_tvalid rises with its first result item.
// Reset clears the sextet group, the counter, the queue and the output valid flag.
// When the receiver holds m_axis_tready low, the output item holds, the queue
// fills, and s_axis_tready drops once four jobs are waiting.
module base64_stream_decoder import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] data_byte, [23:8] decoded_length,
                                       // [24] dangling_error, [31:25] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // [0] kind
);

    t_job   job;
    logic   push;
    logic   pop;
    t_qstat qstat;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_char      (s_axis_tdata),
        .i_full      (qstat.full),
        .o_push      (push),
        .o_job       (job)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_stat  (qstat)
    );

    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_user  (m_axis_tuser)
    );

    // A report always closes the run of items caused by its character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("report item without tlast");

    // Data items carry no length and no error flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[24:8] == 17'd0))
        else $error("data item with report fields set");

    // A report never carries a byte, and padding bits stay zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[31:25] == 7'd0)
                           && (!m_axis_tuser || m_axis_tdata[7:0] == 8'd0)))
        else $error("stray bits in output item");

    // The queue pops only entries that exist.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty job queue");

endmodule
